>>> sv/tmae_pkg.sv
package tmae_pkg;

  localparam int unsigned MaskRegs = 4;
  localparam int unsigned MaskW    = 18;
  localparam int unsigned TableW   = 12;
  localparam int unsigned CodeW    = 3;
  localparam int unsigned TempW    = 16;

  localparam logic signed [TempW-1:0] MaxStart = 16'sd0;
  localparam logic signed [TempW-1:0] MinStart = 16'sd100;

  localparam logic       OpSample  = 1'b0;
  localparam logic       OpScanEnd = 1'b1;

  localparam logic [2:0] CfgMask0    = 3'd0;
  localparam logic [2:0] CfgMask1    = 3'd1;
  localparam logic [2:0] CfgMask2    = 3'd2;
  localparam logic [2:0] CfgMask3    = 3'd3;
  localparam logic [2:0] CfgMuxTable = 3'd4;

  typedef enum logic [4:0] {
    StClear  = 5'b00001,
    StIdle   = 5'b00010,
    StWalk   = 5'b00100,
    StDrain  = 5'b01000,
    StFinish = 5'b10000
  } state_e;

  typedef struct packed {
    logic [4:0] sensor;
    logic [2:0] level;
    logic       last;
  } tag_t;

  typedef struct packed {
    logic                    valid;
    tag_t                    tag;
    logic signed [TempW-1:0] value;
  } avg_word_t;

  typedef struct packed {
    logic                    max_found;
    logic [4:0]              max_sensor;
    logic [1:0]              hot_level;
    logic signed [TempW-1:0] max_average;
    logic                    min_found;
    logic [4:0]              min_sensor;
    logic [1:0]              cold_level;
    logic signed [TempW-1:0] min_average;
  } ext_res_t;

  function automatic logic [CodeW-1:0] mux_code_of(input logic [TableW-1:0] tbl,
                                                   input logic [2:0] lvl);
    logic [CodeW-1:0] code;
    code = '0;
    if (32'(lvl) < MaskRegs) begin
      code = tbl[3*32'(lvl) +: CodeW];
    end
    return code;
  endfunction

endpackage

>>> sv/tmae_hist_mem.sv
module tmae_hist_mem #(
  parameter int unsigned DEPTH = 576,
  parameter int unsigned AW    = 10
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [AW-1:0]                        waddr_i,
  input  logic signed [tmae_pkg::TempW-1:0]    wdata_i,
  input  logic                                 re_i,
  input  logic [AW-1:0]                        raddr_i,
  output logic signed [tmae_pkg::TempW-1:0]    rdata_o
);

  logic signed [tmae_pkg::TempW-1:0] mem_q [DEPTH];
  logic signed [tmae_pkg::TempW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/tmae_avg.sv
module tmae_avg #(
  parameter int unsigned AVG_DEPTH = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic                               first_i,
  input  logic                               last_i,
  input  tmae_pkg::tag_t                     tag_i,
  input  logic signed [tmae_pkg::TempW-1:0]  data_i,
  output tmae_pkg::avg_word_t                avg_o
);

  localparam int unsigned LogDepth = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 0;
  localparam int unsigned MagW     = tmae_pkg::TempW + LogDepth;
  localparam int unsigned SumW     = MagW + 1;
  localparam int unsigned Shift    = MagW + LogDepth;
  localparam int unsigned RecipW   = MagW + 1;
  localparam int unsigned ProdW    = MagW + RecipW;
  localparam logic [63:0] RecipFull =
    ((64'd1 << Shift) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipFull);

  logic signed [SumW-1:0] acc_q, sum_d;
  logic                   v2_q, v3_q, v4_q;
  tmae_pkg::tag_t         tag2_q, tag3_q, tag4_q;
  logic signed [SumW-1:0] sum2_q;
  logic [MagW-1:0]        mag3_q;
  logic                   neg3_q, neg4_q;
  logic [ProdW-1:0]       prod4_q;
  logic [ProdW-Shift-1:0] quot;

  assign sum_d = (first_i ? SumW'(0) : acc_q) + SumW'(data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v2_q <= valid_i & last_i;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      acc_q <= sum_d;
    end
    sum2_q  <= sum_d;
    tag2_q  <= tag_i;
    neg3_q  <= sum2_q[SumW-1];
    mag3_q  <= sum2_q[SumW-1] ? MagW'(-sum2_q) : MagW'(sum2_q);
    tag3_q  <= tag2_q;
    prod4_q <= ProdW'(mag3_q) * ProdW'(Recip);
    neg4_q  <= neg3_q;
    tag4_q  <= tag3_q;
  end

  assign quot = prod4_q[ProdW-1:Shift];

  always_comb begin
    avg_o.valid = v4_q;
    avg_o.tag   = tag4_q;
    avg_o.value = neg4_q ? tmae_pkg::TempW'(-quot) : tmae_pkg::TempW'(quot);
  end

endmodule

>>> sv/tmae_extrema.sv
module tmae_extrema (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  tmae_pkg::avg_word_t avg_i,
  output tmae_pkg::ext_res_t  res_o,
  output logic                done_o
);

  logic                              max_found_q, min_found_q, done_q;
  logic [4:0]                        max_sensor_q, min_sensor_q;
  logic [2:0]                        max_lvl_q, min_lvl_q;
  logic signed [tmae_pkg::TempW-1:0] max_v_q, min_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_found_q <= 1'b0;
      min_found_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      done_q <= avg_i.valid & avg_i.tag.last;
      if (start_i) begin
        max_found_q <= 1'b0;
        min_found_q <= 1'b0;
      end else if (avg_i.valid) begin
        if (avg_i.value > max_v_q) begin
          max_found_q <= 1'b1;
        end
        if (avg_i.value < min_v_q) begin
          min_found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      max_v_q <= tmae_pkg::MaxStart;
      min_v_q <= tmae_pkg::MinStart;
    end else if (avg_i.valid) begin
      if (avg_i.value > max_v_q) begin
        max_v_q      <= avg_i.value;
        max_sensor_q <= avg_i.tag.sensor;
        max_lvl_q    <= avg_i.tag.level;
      end
      if (avg_i.value < min_v_q) begin
        min_v_q      <= avg_i.value;
        min_sensor_q <= avg_i.tag.sensor;
        min_lvl_q    <= avg_i.tag.level;
      end
    end
  end

  always_comb begin
    res_o.max_found   = max_found_q;
    res_o.max_sensor  = max_found_q ? max_sensor_q : '0;
    res_o.hot_level   = max_found_q ? max_lvl_q[1:0] : '0;
    res_o.max_average = max_found_q ? max_v_q : '0;
    res_o.min_found   = min_found_q;
    res_o.min_sensor  = min_found_q ? min_sensor_q : '0;
    res_o.cold_level  = min_found_q ? min_lvl_q[1:0] : '0;
    res_o.min_average = min_found_q ? min_v_q : '0;
  end

  assign done_o = done_q;

endmodule

>>> sv/multiplexed_temperature_average_extrema_top.sv
// Temperature averaging over a multiplexed sensor array with a max/min scan. A sample word
// stages one temperature. An end-of-scan word with scan_complete low moves straight to the
// finish state; its result is registered once output is not stalled. With scan_complete
// high the block walks the whole history, LEVELS*SENSORS*AVG_DEPTH words (576 by default),
// through the history memory's read port, one word per cycle, storing the enabled staged
// sensors into the current level and slot on the way; the averaging pipeline and extrema
// scan then drain before the result. After reset the history is cleared at every address,
// during which no input word is taken. Configuration writes are taken in every cycle.
module multiplexed_temperature_average_extrema_top #(
  parameter int unsigned SENSORS   = 18,
  parameter int unsigned LEVELS    = 4,
  parameter int unsigned AVG_DEPTH = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                operation_i,
  input  logic [4:0]                          sensor_index_i,
  input  logic signed [tmae_pkg::TempW-1:0]   temperature_i,
  input  logic                                scan_complete_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                report_valid_o,
  output logic                                max_found_o,
  output logic [4:0]                          max_sensor_o,
  output logic [1:0]                          hot_level_o,
  output logic signed [tmae_pkg::TempW-1:0]   max_average_o,
  output logic                                min_found_o,
  output logic [4:0]                          min_sensor_o,
  output logic [1:0]                          cold_level_o,
  output logic signed [tmae_pkg::TempW-1:0]   min_average_o,
  output logic [tmae_pkg::CodeW-1:0]          next_mux_code_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [2:0]                          cfg_index_i,
  input  logic [tmae_pkg::MaskW-1:0]          cfg_data_i
);

  localparam int unsigned LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned SW    = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int unsigned DW    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int unsigned Depth = LEVELS * SENSORS * AVG_DEPTH;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  tmae_pkg::state_e state_q, state_d;

  logic [tmae_pkg::MaskRegs-1:0][tmae_pkg::MaskW-1:0] mask_q;
  logic [tmae_pkg::TableW-1:0]                        table_q;
  logic signed [tmae_pkg::TempW-1:0]                  staged_q [SENSORS];

  logic [LW-1:0] level_q, level_nxt, l_q;
  logic [DW-1:0] slot_q, slot_nxt, a_q;
  logic [SW-1:0] c_q;
  logic [AW-1:0] addr_q;
  logic          rep_q;

  logic                              s1_v_q, s1_tgt_q, s1_first_q, s1_lasta_q;
  logic signed [tmae_pkg::TempW-1:0] s1_wdata_q, s1_data;
  logic [AW-1:0]                     s1_addr_q;
  tmae_pkg::tag_t                    s1_tag_q;

  logic                              in_acc, walk_last, en, tgt, out_load, ext_start, ext_done;
  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr;
  logic signed [tmae_pkg::TempW-1:0] mem_wdata, mem_rdata;
  tmae_pkg::avg_word_t               avg_w;
  tmae_pkg::ext_res_t                ext_res;

  logic                              out_valid_q;
  tmae_pkg::ext_res_t                out_res_q;
  logic                              out_rep_q;
  logic [tmae_pkg::CodeW-1:0]        out_code_q;

  assign in_stall_o  = (state_q != tmae_pkg::StIdle);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign level_nxt = (level_q == LW'(LEVELS - 1)) ? '0 : level_q + 1'b1;
  assign slot_nxt  = (slot_q == DW'(AVG_DEPTH - 1)) ? '0 : slot_q + 1'b1;
  assign walk_last = (l_q == LW'(LEVELS - 1)) && (c_q == SW'(SENSORS - 1)) &&
                     (a_q == DW'(AVG_DEPTH - 1));

  always_comb begin
    en = 1'b0;
    if (32'(l_q) < tmae_pkg::MaskRegs && 32'(c_q) < tmae_pkg::MaskW) begin
      en = mask_q[2'(l_q)][5'(c_q)];
    end
  end

  assign tgt       = (l_q == level_q) && (a_q == slot_q) && en;
  assign ext_start = in_acc && (operation_i == tmae_pkg::OpScanEnd) && scan_complete_i;
  assign out_load  = (state_q == tmae_pkg::StFinish) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      tmae_pkg::StClear: begin
        if (addr_q == AW'(Depth - 1)) begin
          state_d = tmae_pkg::StIdle;
        end
      end
      tmae_pkg::StIdle: begin
        if (in_acc && operation_i == tmae_pkg::OpScanEnd) begin
          state_d = scan_complete_i ? tmae_pkg::StWalk : tmae_pkg::StFinish;
        end
      end
      tmae_pkg::StWalk: begin
        if (walk_last) begin
          state_d = tmae_pkg::StDrain;
        end
      end
      tmae_pkg::StDrain: begin
        if (ext_done) begin
          state_d = tmae_pkg::StFinish;
        end
      end
      tmae_pkg::StFinish: begin
        if (out_load) begin
          state_d = tmae_pkg::StIdle;
        end
      end
      default: state_d = tmae_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tmae_pkg::StClear;
      mask_q  <= {tmae_pkg::MaskRegs{{tmae_pkg::MaskW{1'b1}}}};
      table_q <= 12'd1990;
      level_q <= '0;
      slot_q  <= '0;
      addr_q  <= '0;
      l_q     <= '0;
      c_q     <= '0;
      a_q     <= '0;
      rep_q   <= 1'b0;
      s1_v_q  <= 1'b0;
      for (int i = 0; i < SENSORS; i++) begin
        staged_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          tmae_pkg::CfgMask0:    mask_q[0] <= cfg_data_i;
          tmae_pkg::CfgMask1:    mask_q[1] <= cfg_data_i;
          tmae_pkg::CfgMask2:    mask_q[2] <= cfg_data_i;
          tmae_pkg::CfgMask3:    mask_q[3] <= cfg_data_i;
          tmae_pkg::CfgMuxTable: table_q   <= cfg_data_i[tmae_pkg::TableW-1:0];
          default: ;
        endcase
      end
      if (in_acc && operation_i == tmae_pkg::OpSample &&
          {1'b0, sensor_index_i} < 6'(SENSORS)) begin
        staged_q[SW'(sensor_index_i)] <= temperature_i;
      end
      if (in_acc && operation_i == tmae_pkg::OpScanEnd) begin
        rep_q  <= scan_complete_i;
        addr_q <= '0;
        l_q    <= '0;
        c_q    <= '0;
        a_q    <= '0;
      end
      if (state_q == tmae_pkg::StClear) begin
        addr_q <= (addr_q == AW'(Depth - 1)) ? '0 : addr_q + 1'b1;
      end
      s1_v_q <= (state_q == tmae_pkg::StWalk);
      if (state_q == tmae_pkg::StWalk) begin
        addr_q <= addr_q + 1'b1;
        if (a_q == DW'(AVG_DEPTH - 1)) begin
          a_q <= '0;
          if (c_q == SW'(SENSORS - 1)) begin
            c_q <= '0;
            l_q <= l_q + 1'b1;
          end else begin
            c_q <= c_q + 1'b1;
          end
        end else begin
          a_q <= a_q + 1'b1;
        end
      end
      if (out_load) begin
        level_q <= level_nxt;
        slot_q  <= slot_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tgt_q        <= tgt;
    s1_wdata_q      <= staged_q[c_q];
    s1_addr_q       <= addr_q;
    s1_first_q      <= (a_q == '0);
    s1_lasta_q      <= (a_q == DW'(AVG_DEPTH - 1));
    s1_tag_q.sensor <= 5'(c_q);
    s1_tag_q.level  <= 3'(l_q);
    s1_tag_q.last   <= walk_last;
  end

  assign mem_we    = (state_q == tmae_pkg::StClear) | (s1_v_q & s1_tgt_q);
  assign mem_waddr = (state_q == tmae_pkg::StClear) ? addr_q : s1_addr_q;
  assign mem_wdata = (state_q == tmae_pkg::StClear) ? '0 : s1_wdata_q;
  assign s1_data   = s1_tgt_q ? s1_wdata_q : mem_rdata;

  tmae_hist_mem #(
    .DEPTH (Depth),
    .AW    (AW)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (state_q == tmae_pkg::StWalk),
    .raddr_i (addr_q),
    .rdata_o (mem_rdata)
  );

  tmae_avg #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_avg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_v_q),
    .first_i (s1_first_q),
    .last_i  (s1_lasta_q),
    .tag_i   (s1_tag_q),
    .data_i  (s1_data),
    .avg_o   (avg_w)
  );

  tmae_extrema u_ext (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ext_start),
    .avg_i   (avg_w),
    .res_o   (ext_res),
    .done_o  (ext_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rep_q  <= rep_q;
      out_res_q  <= rep_q ? ext_res : '0;
      out_code_q <= tmae_pkg::mux_code_of(table_q, 3'(level_nxt));
    end
  end

  assign out_valid_o     = out_valid_q;
  assign report_valid_o  = out_rep_q;
  assign max_found_o     = out_res_q.max_found;
  assign max_sensor_o    = out_res_q.max_sensor;
  assign hot_level_o     = out_res_q.hot_level;
  assign max_average_o   = out_res_q.max_average;
  assign min_found_o     = out_res_q.min_found;
  assign min_sensor_o    = out_res_q.min_sensor;
  assign cold_level_o    = out_res_q.cold_level;
  assign min_average_o   = out_res_q.min_average;
  assign next_mux_code_o = out_code_q;

  a_done_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ext_done |-> state_q == tmae_pkg::StDrain)
    else $error("extrema scan finished outside drain");

  a_store_cur_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && s1_tgt_q) |-> s1_tag_q.level == 3'(level_q))
    else $error("history store outside current level");

  a_counters_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_load |=> $stable(level_q) && $stable(slot_q))
    else $error("level or slot moved without a result");

  a_no_report_no_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !report_valid_o) |-> (!max_found_o && !min_found_o))
    else $error("extremum flagged on incomplete scan");

endmodule
